[sv/lcsc_pkg.sv]
// ----------------------------------------------------------------------------
// lcsc_pkg
// shared constants and types for the load cell settle and classify block
// ----------------------------------------------------------------------------
package lcsc_pkg;

    localparam int NUM_CELLS  = 3;
    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 15;
    localparam int PROD_W     = RAW_W + GAIN_W;
    localparam int QUO_W      = 17;
    localparam int OFS_W      = 17;
    localparam int WEIGHT_W   = 19;
    localparam int TARGET_W   = 16;
    localparam int RUN_W      = 4;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 19;

    localparam logic [RUN_W-1:0] SETTLE_RUN = 4'd10;

    // x / 10000 == (x * RECIP) >> RECIP_SHIFT, exact for any 32-bit x
    localparam logic [31:0] RECIP       = 32'hD1B7_1759;
    localparam int          RECIP_SHIFT = 45;

    // magnitude of the negative gain per cell
    localparam logic [GAIN_W-1:0] CELL_GAIN [NUM_CELLS] = '{
        15'd16398, 15'd16521, 15'd16722
    };
    localparam logic [OFS_W-1:0] CELL_OFS [NUM_CELLS] = '{
        17'd60630, 17'd64998, 17'd65884
    };

    localparam logic [CFG_IDX_W-1:0] REG_TARE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_CORRECT = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_EMPTY   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_WRONG   = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic signed [WEIGHT_W-1:0] total;
    } lcsc_total_t;

endpackage

[sv/lcsc_cal.sv]
// ----------------------------------------------------------------------------
// lcsc_cal
// four-stage calibration pipeline: raw readings to summed grams
// ----------------------------------------------------------------------------
module lcsc_cal
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lcsc_pkg::RAW_W-1:0]    cell_raw_0,
    input  logic [lcsc_pkg::RAW_W-1:0]    cell_raw_1,
    input  logic [lcsc_pkg::RAW_W-1:0]    cell_raw_2,
    output lcsc_pkg::lcsc_total_t         tot,
    input  logic                          tot_ready
);

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic                          adv1, adv2, adv3, adv4;
    logic [lcsc_pkg::RAW_W-1:0]    raw_reg  [lcsc_pkg::NUM_CELLS];
    logic [lcsc_pkg::PROD_W-1:0]   prod_reg [lcsc_pkg::NUM_CELLS];
    logic [lcsc_pkg::QUO_W-1:0]    quo_reg  [lcsc_pkg::NUM_CELLS];
    logic [lcsc_pkg::PROD_W-1:0]   prod_next [lcsc_pkg::NUM_CELLS];
    logic [lcsc_pkg::QUO_W-1:0]    quo_next  [lcsc_pkg::NUM_CELLS];
    logic [63:0]                   recip_prod [lcsc_pkg::NUM_CELLS];
    logic signed [lcsc_pkg::WEIGHT_W-1:0] total_reg, total_next;

    // each stage moves when it is empty or the next one moves
    assign adv4     = !v4_reg || tot_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        total_next = '0;
        for (int i = 0; i < lcsc_pkg::NUM_CELLS; i++)
        begin
            prod_next[i]  = lcsc_pkg::PROD_W'(raw_reg[i]) *
                            lcsc_pkg::PROD_W'(lcsc_pkg::CELL_GAIN[i]);
            recip_prod[i] = 64'(prod_reg[i]) * 64'(lcsc_pkg::RECIP);
            quo_next[i]   = recip_prod[i][lcsc_pkg::RECIP_SHIFT +: lcsc_pkg::QUO_W];
            // truncation toward zero of a negative product is minus the quotient
            total_next    = total_next
                          + $signed(lcsc_pkg::WEIGHT_W'(lcsc_pkg::CELL_OFS[i]))
                          - $signed(lcsc_pkg::WEIGHT_W'(quo_reg[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            raw_reg[0] <= cell_raw_0;
            raw_reg[1] <= cell_raw_1;
            raw_reg[2] <= cell_raw_2;
        end
        if (adv2 && v1_reg)
            prod_reg <= prod_next;
        if (adv3 && v2_reg)
            quo_reg <= quo_next;
        if (adv4 && v3_reg)
            total_reg <= total_next;
    end

    assign tot.valid = v4_reg;
    assign tot.total = total_reg;

endmodule

[sv/lcsc_settle.sv]
// ----------------------------------------------------------------------------
// lcsc_settle
// settle detector, run counter, classifier and result register
// ----------------------------------------------------------------------------
module lcsc_settle
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lcsc_pkg::lcsc_total_t                 tot,
    output logic                                  tot_ready,
    input  logic signed [lcsc_pkg::WEIGHT_W-1:0]  tare,
    input  logic [lcsc_pkg::TARGET_W-1:0]         target,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lcsc_pkg::WEIGHT_W-1:0]  total_weight,
    output logic [lcsc_pkg::RUN_W-1:0]            stable_run,
    output logic                                  decided,
    output logic [lcsc_pkg::CLASS_W-1:0]          glass_class
);

    logic signed [lcsc_pkg::WEIGHT_W-1:0] ref_reg, ref_next;
    logic [lcsc_pkg::RUN_W-1:0]           run_reg, run_next, run_new;
    logic                                 out_valid_reg;
    logic signed [lcsc_pkg::WEIGHT_W-1:0] total_reg;
    logic [lcsc_pkg::RUN_W-1:0]           shown_reg;
    logic                                 decided_reg;
    logic [lcsc_pkg::CLASS_W-1:0]         class_reg, class_next;

    logic                                 take;
    logic signed [lcsc_pkg::WEIGHT_W:0]   diff;
    logic                                 near;
    logic                                 dec;
    logic signed [lcsc_pkg::WEIGHT_W:0]   net;
    logic signed [lcsc_pkg::WEIGHT_W+1:0] tgt_err;
    logic                                 is_correct, is_empty;

    assign tot_ready = !out_valid_reg || out_ready;
    assign take      = tot.valid && tot_ready;

    always_comb
    begin
        diff = $signed({ref_reg[lcsc_pkg::WEIGHT_W-1], ref_reg})
             - $signed({tot.total[lcsc_pkg::WEIGHT_W-1], tot.total});
        // a near match is 1 to 9 grams either way, never equal
        near = (diff != '0) && (diff < 20'sd10) && (diff > -20'sd10);
        run_new = near ? run_reg + 4'd1 : '0;
        dec  = run_new >= lcsc_pkg::SETTLE_RUN;

        net  = $signed({tot.total[lcsc_pkg::WEIGHT_W-1], tot.total})
             - $signed({tare[lcsc_pkg::WEIGHT_W-1], tare});
        tgt_err = $signed({5'b0_0000, target})
                - $signed({net[lcsc_pkg::WEIGHT_W], net});
        is_correct = (tgt_err > -21'sd20) && (tgt_err < 21'sd20);
        is_empty   = (net > -20'sd60) && (net < 20'sd60);

        if (!dec || is_correct)
            class_next = lcsc_pkg::CLS_CORRECT;
        else if (is_empty)
            class_next = lcsc_pkg::CLS_EMPTY;
        else
            class_next = lcsc_pkg::CLS_WRONG;

        // a verdict sends the detector back to its reset state
        if (dec)
        begin
            ref_next = '0;
            run_next = '0;
        end
        else
        begin
            ref_next = near ? ref_reg : tot.total;
            run_next = run_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ref_reg       <= ref_next;
                run_reg       <= run_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            total_reg   <= tot.total;
            shown_reg   <= run_new;
            decided_reg <= dec;
            class_reg   <= class_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign total_weight = total_reg;
    assign stable_run   = shown_reg;
    assign decided      = decided_reg;
    assign glass_class  = class_reg;

endmodule

[sv/load_cell_settle_classify.sv]
// ----------------------------------------------------------------------------
// load_cell_settle_classify
// calibrates three load cells, detects a settled weight and classifies it
// ----------------------------------------------------------------------------
// path: an accepted word passes the four calibration stages, then the result
//   register of the settle stage, before it shows on out_valid
// throughput: one word per cycle while out_ready does not stall the pipeline
// reset: rst_n clears tare, target, reference weight, run count and all valids
// ----------------------------------------------------------------------------
module load_cell_settle_classify
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [lcsc_pkg::RAW_W-1:0]              cell_raw_0,
    input  logic [lcsc_pkg::RAW_W-1:0]              cell_raw_1,
    input  logic [lcsc_pkg::RAW_W-1:0]              cell_raw_2,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [lcsc_pkg::WEIGHT_W-1:0]    total_weight,
    output logic [lcsc_pkg::RUN_W-1:0]              stable_run,
    output logic                                    decided,
    output logic [lcsc_pkg::CLASS_W-1:0]            glass_class,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lcsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lcsc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic signed [lcsc_pkg::WEIGHT_W-1:0] tare_reg;
    logic [lcsc_pkg::TARGET_W-1:0]        target_reg;
    lcsc_pkg::lcsc_total_t                tot;
    logic                                 tot_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg   <= '0;
            target_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lcsc_pkg::REG_TARE:
                    tare_reg <= $signed(cfg_data[lcsc_pkg::WEIGHT_W-1:0]);
                lcsc_pkg::REG_TARGET:
                    target_reg <= cfg_data[lcsc_pkg::TARGET_W-1:0];
                default:
                    ;
            endcase
        end
    end

    lcsc_cal u_cal
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_raw_0 (cell_raw_0),
        .cell_raw_1 (cell_raw_1),
        .cell_raw_2 (cell_raw_2),
        .tot        (tot),
        .tot_ready  (tot_ready)
    );

    lcsc_settle u_settle
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tot          (tot),
        .tot_ready    (tot_ready),
        .tare         (tare_reg),
        .target       (target_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .total_weight (total_weight),
        .stable_run   (stable_run),
        .decided      (decided),
        .glass_class  (glass_class)
    );

endmodule
